/* rtl/extended_euclid_gcd_core_defines.svh */
// Assertion macros for the extended Euclid GCD core checker.
`ifndef EXTENDED_EUCLID_GCD_CORE_DEFINES_SVH
`define EXTENDED_EUCLID_GCD_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EGCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define EGCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/egcd_pkg.sv */
// Package for the extended Euclid GCD core: default width and sequencer states.
package egcd_pkg;

   localparam int DATA_WIDTH_DEF = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_UPDATE,
      ST_FINISH
   } egcd_state_type;

endpackage

/* rtl/extended_euclid_gcd_core.sv */
// Extended Euclid GCD core: gcd of two operands with Bezout coefficients.
//
// Request channel (req_valid/req_ready) takes operand_a and operand_b,
// DATA_WIDTH-1 bits each, unsigned. Response channel (rsp_valid/rsp_ready)
// returns gcd_value (DATA_WIDTH-1 bits) and the signed coefficients coeff_a
// and coeff_b (DATA_WIDTH bits) with a*coeff_a + b*coeff_b = gcd.
// One response per request, in order.
// A single restoring divider step unit runs every remainder step, one
// quotient bit per cycle; the two coefficient products are built alongside
// it by shift-and-add. One Euclid step runs a check, one divide step per
// quotient bit, then an update. The number n of remainder steps is data
// dependent (0 when operand_a is zero, at most about 46 for 31-bit
// operands). req_ready is high only while idle, so a new request is not
// taken before the sequencer has finished the last one. The finished
// result sits in an output register, so a new request may be taken while
// the response still waits; if the register is full when the next result
// is done, the sequencer holds until rsp_ready frees it.
// Synchronous active-high reset returns the sequencer to idle and drops
// rsp_valid; no clearing pass is needed.
module extended_euclid_gcd_core #(
   parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [DATA_WIDTH-2:0]        req_operand_a,
   input  logic [DATA_WIDTH-2:0]        req_operand_b,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [DATA_WIDTH-2:0]        rsp_gcd_value,
   output logic signed [DATA_WIDTH-1:0] rsp_coeff_a,
   output logic signed [DATA_WIDTH-1:0] rsp_coeff_b
);
   import egcd_pkg::*;

   localparam int OpW  = DATA_WIDTH - 1;
   localparam int CfW  = DATA_WIDTH;
   localparam int CntW = $clog2(OpW);

   egcd_state_type state_ff, state_in;

   logic [OpW-1:0]  ra_ff, ra_in, rb_ff, rb_in;
   logic [CfW-1:0]  xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic [OpW-1:0]  rem_ff, rem_in, dvd_ff, dvd_in;
   logic [CfW-1:0]  accx_ff, accx_in, accy_ff, accy_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [OpW-1:0]  rsp_gcd_ff, rsp_gcd_in;
   logic [CfW-1:0]  rsp_xa_ff, rsp_xa_in, rsp_yb_ff, rsp_yb_in;

   logic [OpW:0]    trial;
   logic [OpW:0]    trial_diff;
   logic            qbit;

   assign trial      = {rem_ff, dvd_ff[OpW-1]};
   assign trial_diff = trial - {1'b0, ra_ff};
   assign qbit       = (trial >= {1'b0, ra_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ra_ff      <= ra_in;
      rb_ff      <= rb_in;
      xa_ff      <= xa_in;
      ya_ff      <= ya_in;
      xb_ff      <= xb_in;
      yb_ff      <= yb_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      accx_ff    <= accx_in;
      accy_ff    <= accy_in;
      cnt_ff     <= cnt_in;
      rsp_gcd_ff <= rsp_gcd_in;
      rsp_xa_ff  <= rsp_xa_in;
      rsp_yb_ff  <= rsp_yb_in;
   end

   always_comb begin
      state_in     = state_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      xa_in        = xa_ff;
      ya_in        = ya_ff;
      xb_in        = xb_ff;
      yb_in        = yb_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      cnt_in       = cnt_ff;
      rsp_gcd_in   = rsp_gcd_ff;
      rsp_xa_in    = rsp_xa_ff;
      rsp_yb_in    = rsp_yb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ra_in    = req_operand_a;
               rb_in    = req_operand_b;
               xa_in    = CfW'(1);
               ya_in    = '0;
               xb_in    = '0;
               yb_in    = CfW'(1);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (ra_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               rem_in   = '0;
               dvd_in   = rb_ff;
               accx_in  = '0;
               accy_in  = '0;
               cnt_in   = CntW'(OpW - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = qbit ? trial_diff[OpW-1:0] : trial[OpW-1:0];
            dvd_in  = {dvd_ff[OpW-2:0], 1'b0};
            accx_in = {accx_ff[CfW-2:0], 1'b0} + (qbit ? xa_ff : '0);
            accy_in = {accy_ff[CfW-2:0], 1'b0} + (qbit ? ya_ff : '0);
            cnt_in  = cnt_ff - CntW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            rb_in    = ra_ff;
            ra_in    = rem_ff;
            xb_in    = xa_ff;
            yb_in    = ya_ff;
            xa_in    = xb_ff - accx_ff;
            ya_in    = yb_ff - accy_ff;
            state_in = ST_CHECK;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_gcd_in   = rb_ff;
               rsp_xa_in    = xb_ff;
               rsp_yb_in    = yb_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_gcd_value = rsp_gcd_ff;
   assign rsp_coeff_a   = rsp_xa_ff;
   assign rsp_coeff_b   = rsp_yb_ff;

endmodule

/* rtl/egcd_checker.sv */
// Port-level checker for the extended Euclid GCD core, with its bind.
`include "extended_euclid_gcd_core_defines.svh"

module egcd_checker #(
   parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [DATA_WIDTH-2:0]        rsp_gcd_value,
   input logic signed [DATA_WIDTH-1:0] rsp_coeff_a,
   input logic signed [DATA_WIDTH-1:0] rsp_coeff_b
);

   `EGCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `EGCD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_gcd_value) && $stable(rsp_coeff_a) && $stable(rsp_coeff_b), "response changed while stalled")
   `EGCD_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   `EGCD_ASSERT_NOW(a_zero_gcd, clock, reset, rsp_valid && (rsp_gcd_value == '0), (rsp_coeff_a == '0) && (rsp_coeff_b == 1), "zero gcd with wrong coefficients")

endmodule

bind extended_euclid_gcd_core egcd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_egcd_checker (.*);

/* sim/testbench.sv */
// Testbench for extended_euclid_gcd_core: directed and random requests checked by a Bezout predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_WIDTH     = egcd_pkg::DATA_WIDTH_DEF;
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int DRAIN_CYCLES   = 60;

   typedef logic [DATA_WIDTH-2:0] operand_type;
   typedef logic [DATA_WIDTH-1:0] coeff_type;

   typedef struct packed {
      operand_type operand_a;
      operand_type operand_b;
      operand_type gcd_value;
      coeff_type   coeff_a;
      coeff_type   coeff_b;
   } bezout_type;

   typedef enum logic [1:0] {RX_ALWAYS, RX_CHOPPY, RX_LONG_STALLS} rx_mode_type;

   localparam operand_type OPERAND_MAX = '1;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   operand_type                  req_operand_a = '0;
   operand_type                  req_operand_b = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [DATA_WIDTH-2:0]        rsp_gcd_value;
   logic signed [DATA_WIDTH-1:0] rsp_coeff_a;
   logic signed [DATA_WIDTH-1:0] rsp_coeff_b;

   bezout_type  pending_results[$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   rx_mode_type rx_mode = RX_ALWAYS;
   int          rx_hold = 0;

   extended_euclid_gcd_core #(.DATA_WIDTH(DATA_WIDTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_gcd_value (rsp_gcd_value),
      .rsp_coeff_a   (rsp_coeff_a),
      .rsp_coeff_b   (rsp_coeff_b)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // forward Euclid loop; coefficients wrap at the output width
   function automatic bezout_type predict_bezout(input operand_type a, input operand_type b);
      operand_type rem_a, rem_b, quot, rem_next;
      coeff_type   xa, ya, xb, yb, nx, ny;
      bezout_type  res;
      rem_a = a;
      rem_b = b;
      xa = 1;
      ya = 0;
      xb = 0;
      yb = 1;
      while (rem_a != 0) begin
         quot     = rem_b / rem_a;
         rem_next = rem_b % rem_a;
         nx       = xb - coeff_type'(quot) * xa;
         ny       = yb - coeff_type'(quot) * ya;
         rem_b    = rem_a;
         xb       = xa;
         yb       = ya;
         rem_a    = rem_next;
         xa       = nx;
         ya       = ny;
      end
      res.operand_a = a;
      res.operand_b = b;
      res.gcd_value = rem_b;
      res.coeff_a   = xb;
      res.coeff_b   = yb;
      return res;
   endfunction

   function automatic longint unsigned fib(input int k);
      longint unsigned f0, f1, t;
      f0 = 0;
      f1 = 1;
      for (int i = 0; i < k; i++) begin
         t  = f0 + f1;
         f0 = f1;
         f1 = t;
      end
      return f0;
   endfunction

   function automatic operand_type rand_operand();
      int unsigned pick;
      int unsigned sh;
      pick = $urandom_range(0, 99);
      sh   = $urandom_range(0, DATA_WIDTH - 2);
      if (pick < 40) return operand_type'($urandom);
      else if (pick < 60) return operand_type'($urandom_range(0, 255));
      else if (pick < 75) return operand_type'($urandom_range(0, 65535));
      else if (pick < 80) return '0;
      else if (pick < 85) return OPERAND_MAX;
      else if (pick < 88) return operand_type'(1);
      else return operand_type'((64'd1 << sh) + $urandom_range(0, 2) - 1);
   endfunction

   task automatic send_request(input operand_type a, input operand_type b);
      req_valid     <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_bezout(a, b));
   endtask

   // bursts of back-to-back requests, most separated by random gaps
   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_special_cases();
      rx_mode <= RX_CHOPPY;
      send_request(0, 0);
      send_request(0, 12345);
      send_request(0, OPERAND_MAX);
      send_request(98765, 0);
      send_request(OPERAND_MAX, 0);
      send_request(1, 0);
      send_request(0, 1);
      send_request(1, 1);
      send_request(OPERAND_MAX, OPERAND_MAX);
      send_request(OPERAND_MAX, 1);
      send_request(1, OPERAND_MAX);
      send_request(OPERAND_MAX, OPERAND_MAX - 1);
      send_request(OPERAND_MAX - 1, OPERAND_MAX);
      send_request(6, 4);
      send_request(4, 6);
      send_request(240, 46);
      send_request(operand_type'(fib(45)), operand_type'(fib(46)));
      send_request(operand_type'(fib(46)), operand_type'(fib(45)));
      send_request(operand_type'(1 << 30), operand_type'(1 << 29));
      send_request(operand_type'(32'h2AAA_AAAA), operand_type'(32'h5555_5555));
   endtask

   task automatic test_small_operands();
      rx_mode <= RX_ALWAYS;
      repeat (60) begin
         send_request(operand_type'($urandom_range(0, 63)),
                      operand_type'($urandom_range(0, 63)));
      end
   endtask

   // consecutive Fibonacci pairs give the longest remainder chains
   task automatic test_fibonacci_pairs();
      int              k;
      longint unsigned lo, hi, scale;
      rx_mode <= RX_LONG_STALLS;
      repeat (40) begin
         pace_sender();
         k     = $urandom_range(1, 45);
         lo    = fib(k);
         hi    = fib(k + 1);
         scale = $urandom_range(1, int'(longint'(OPERAND_MAX) / hi));
         if ($urandom_range(0, 1) != 0)
            send_request(operand_type'(lo * scale), operand_type'(hi * scale));
         else
            send_request(operand_type'(hi * scale), operand_type'(lo * scale));
      end
   endtask

   task automatic test_common_factors();
      longint unsigned g, m, n;
      rx_mode <= RX_CHOPPY;
      repeat (80) begin
         pace_sender();
         g = $urandom_range(1, 1 << 16);
         m = $urandom_range(0, int'(longint'(OPERAND_MAX) / g));
         n = $urandom_range(0, int'(longint'(OPERAND_MAX) / g));
         send_request(operand_type'(g * m), operand_type'(g * n));
      end
   endtask

   task automatic test_full_range();
      for (int i = 0; i < 250; i++) begin
         if (i % 50 == 0) rx_mode <= rx_mode_type'($urandom_range(0, 2));
         pace_sender();
         send_request(rand_operand(), rand_operand());
      end
   endtask

   always @(posedge clock) begin
      if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
      end else begin
         case (rx_mode)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_CHOPPY: rsp_ready <= 1'($urandom_range(0, 1));
            default: begin
               if (rsp_ready) begin
                  rsp_ready <= 1'b0;
                  rx_hold   <= $urandom_range(5, 40);
               end else begin
                  rsp_ready <= 1'b1;
                  rx_hold   <= $urandom_range(0, 10);
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      bezout_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: gcd_value %0d", rsp_gcd_value);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_gcd_value !== want.gcd_value) begin
               $error("gcd_value (a=%0d b=%0d): expected %0d, actual %0d",
                      want.operand_a, want.operand_b, want.gcd_value, rsp_gcd_value);
               mismatch_count++;
            end
            if (rsp_coeff_a !== want.coeff_a) begin
               $error("coeff_a (a=%0d b=%0d): expected %0d, actual %0d",
                      want.operand_a, want.operand_b, $signed(want.coeff_a), rsp_coeff_a);
               mismatch_count++;
            end
            if (rsp_coeff_b !== want.coeff_b) begin
               $error("coeff_b (a=%0d b=%0d): expected %0d, actual %0d",
                      want.operand_a, want.operand_b, $signed(want.coeff_b), rsp_coeff_b);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_special_cases();
      wait_for_results();
      test_small_operands();
      test_fibonacci_pairs();
      wait_for_results();
      test_common_factors();
      test_full_range();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/egcd_pkg.sv
rtl/extended_euclid_gcd_core.sv
rtl/egcd_checker.sv
sim/testbench.sv
